@@ rtl/fgb_pkg.sv @@
package fgb_pkg;

	localparam int SCREEN_W_DEF = 320;
	localparam int SCREEN_H_DEF = 200;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_X            = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_Y            = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT      = 3'd6;

	localparam logic [7:0] LOWER_A   = "a";
	localparam logic [7:0] LOWER_Z   = "z";
	localparam logic [7:0] CASE_FOLD = 8'h20;

	// last row and column of each font
	localparam logic [2:0] BIG_LAST       = 3'd7;
	localparam logic [2:0] SMALL_LAST_ROW = 3'd4;
	localparam logic [2:0] SMALL_LAST_COL = 3'd2;

	typedef struct packed {
		logic              mode;
		logic [7:0]        char_code;
		logic signed [11:0] origin_x;
		logic signed [11:0] origin_y;
		logic [7:0]        ink;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_address;
		logic [7:0]  pixel_color;
		logic        last_pixel;
	} out_item_t;

	typedef struct packed {
		logic               transform_enable;
		logic signed [11:0] pan_x;
		logic signed [11:0] pan_y;
		logic signed [11:0] clip_left;
		logic signed [11:0] clip_top;
		logic [10:0]        clip_width;
		logic [10:0]        clip_height;
	} cfg_t;

	// one glyph cell issued by the scanner
	typedef struct packed {
		logic               valid;
		logic               last_scan;
		logic               mode;
		logic [7:0]         char_code;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [11:0] origin_x;
		logic signed [11:0] origin_y;
		logic [7:0]         ink;
	} scan_t;

	// one cell after transform, clip and address
	typedef struct packed {
		logic        valid;
		logic        vis;
		logic        last_scan;
		logic [15:0] addr;
		logic [7:0]  color;
	} pix_t;

	// Row of a glyph. Large font: bit 7 is column 0. Small font: bits 2:0, bit 2 is column 0.
	function automatic logic [7:0] glyph_row(input logic mode, input logic [7:0] code,
			input logic [2:0] row);
		logic [63:0] big;
		logic [14:0] small_w;
		logic [14:0] sh;
		logic [7:0]  res;
		big     = '0;
		small_w = '0;
		sh      = '0;
		res     = '0;
		case (code)
			"A": big = 64'h1824_427E_4242_4200;
			"B": big = 64'h7C42_427C_4242_7C00;
			"C": big = 64'h3C42_4040_4042_3C00;
			"D": big = 64'h7844_4242_4244_7800;
			"E": big = 64'h7E40_407C_4040_7E00;
			"F": big = 64'h7E40_407C_4040_4000;
			"G": big = 64'h3C42_404E_4242_3C00;
			"H": big = 64'h4242_427E_4242_4200;
			"I": big = 64'h3C10_1010_1010_3C00;
			"J": big = 64'h1E04_0404_4444_3800;
			"K": big = 64'h4244_4870_4844_4200;
			"L": big = 64'h4040_4040_4040_7E00;
			"M": big = 64'h4266_5A5A_4242_4200;
			"N": big = 64'h4262_524A_4642_4200;
			"O": big = 64'h3C42_4242_4242_3C00;
			"P": big = 64'h7C42_427C_4040_4000;
			"Q": big = 64'h3C42_4242_4A44_3A00;
			"R": big = 64'h7C42_427C_4844_4200;
			"S": big = 64'h3C42_2018_0442_3C00;
			"T": big = 64'h7E10_1010_1010_1000;
			"U": big = 64'h4242_4242_4242_3C00;
			"V": big = 64'h4242_4242_4224_1800;
			"W": big = 64'h4242_425A_5A66_4200;
			"X": big = 64'h4242_2418_2442_4200;
			"Y": big = 64'h4242_2418_1010_1000;
			"Z": big = 64'h7E02_0418_2040_7E00;
			"0": big = 64'h3C46_4A52_6246_3C00;
			"1": big = 64'h1030_1010_1010_3800;
			"2": big = 64'h3C42_020C_3040_7E00;
			"3": big = 64'h3C42_021C_0242_3C00;
			"4": big = 64'h040C_1424_447E_0400;
			"5": big = 64'h7E40_7C02_0242_3C00;
			"6": big = 64'h3C40_7C42_4242_3C00;
			"7": big = 64'h7E42_0408_1010_1000;
			"8": big = 64'h3C42_423C_4242_3C00;
			"9": big = 64'h3C42_423E_0242_3C00;
			".": big = 64'h0000_0000_0018_1800;
			":": big = 64'h0018_1800_0018_1800;
			"!": big = 64'h1010_1010_1000_1000;
			"+": big = 64'h0010_107C_1010_0000;
			"*": big = 64'h0044_2810_2844_0000;
			"=": big = 64'h0000_7C00_7C00_0000;
			"%": big = 64'h6264_0810_2646_0000;
			"/": big = 64'h0204_0810_2040_0000;
			"-": big = 64'h0000_007E_0000_0000;
			default: big = '0;
		endcase
		// five rows of three bits, one octal digit per row, top row first
		case (code)
			".": small_w = 15'o00002;
			"-": small_w = 15'o00700;
			":": small_w = 15'o02020;
			"0": small_w = 15'o75557;
			"1": small_w = 15'o26227;
			"2": small_w = 15'o71747;
			"3": small_w = 15'o71717;
			"4": small_w = 15'o55711;
			"5": small_w = 15'o74717;
			"6": small_w = 15'o74757;
			"7": small_w = 15'o71111;
			"8": small_w = 15'o75757;
			"9": small_w = 15'o75717;
			"A": small_w = 15'o75755;
			"B": small_w = 15'o65656;
			"C": small_w = 15'o74447;
			"D": small_w = 15'o65556;
			"E": small_w = 15'o74647;
			"F": small_w = 15'o74644;
			"G": small_w = 15'o74557;
			"H": small_w = 15'o55755;
			"I": small_w = 15'o72227;
			"J": small_w = 15'o11157;
			"K": small_w = 15'o55655;
			"L": small_w = 15'o44447;
			"M": small_w = 15'o57755;
			"N": small_w = 15'o57775;
			"O": small_w = 15'o75557;
			"P": small_w = 15'o75744;
			"Q": small_w = 15'o75571;
			"R": small_w = 15'o65655;
			"S": small_w = 15'o74717;
			"T": small_w = 15'o72222;
			"U": small_w = 15'o55557;
			"V": small_w = 15'o55552;
			"W": small_w = 15'o55775;
			"X": small_w = 15'o55255;
			"Y": small_w = 15'o55222;
			"Z": small_w = 15'o71247;
			default: small_w = '0;
		endcase
		if (!mode) begin
			res = big[{BIG_LAST - row, 3'b000} +: 8];
		end else if (row <= SMALL_LAST_ROW) begin
			sh  = small_w >> (4'd12 - 4'(row) * 4'd3);
			res = {5'b00000, sh[2:0]};
		end
		return res;
	endfunction

endpackage

@@ rtl/fgb_font_rom.sv @@
module fgb_font_rom
	import fgb_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  scan_t      tok,
	output logic [7:0] rom_row
);

	logic [7:0] row_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1 <= glyph_row(tok.mode, tok.char_code, tok.row);
		end
	end

	assign rom_row = row_s1;

endmodule

@@ rtl/fgb_pixel.sv @@
module fgb_pixel
	import fgb_pkg::*;
#(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  cfg_t       cfg,
	input  scan_t      tok,
	input  logic [7:0] rom_row,
	output pix_t       pix
);

	localparam int XW = $clog2(SCREEN_W);
	localparam int YW = $clog2(SCREEN_H);
	localparam logic signed [13:0] SCR_W = 14'(SCREEN_W);
	localparam logic signed [13:0] SCR_H = 14'(SCREEN_H);

	scan_t tok_s1;

	logic               bit_set;
	logic signed [13:0] x_pos;
	logic signed [13:0] y_pos;

	logic               valid_s2;
	logic               set_s2;
	logic               last_s2;
	logic [7:0]         ink_s2;
	logic signed [13:0] x_s2;
	logic signed [13:0] y_s2;

	logic signed [14:0] x_w;
	logic signed [14:0] y_w;
	logic signed [14:0] clip_l;
	logic signed [14:0] clip_r;
	logic signed [14:0] clip_t;
	logic signed [14:0] clip_b;
	logic               in_clip;
	logic               on_screen;

	logic          valid_s3;
	logic          vis_s3;
	logic          last_s3;
	logic [7:0]    ink_s3;
	logic [XW-1:0] x_s3;
	logic [YW-1:0] y_s3;
	logic [15:0]   row_base;

	// stage 1: ROM row arrives, pick the bit and place the pixel
	always_comb begin
		if (tok_s1.mode) begin
			bit_set = rom_row[SMALL_LAST_COL - tok_s1.col];
		end else begin
			bit_set = rom_row[BIG_LAST - tok_s1.col];
		end
		x_pos = 14'(tok_s1.origin_x) + 14'(tok_s1.col)
			+ (cfg.transform_enable ? 14'(cfg.pan_x) : 14'sd0);
		y_pos = 14'(tok_s1.origin_y) + 14'(tok_s1.row)
			+ (cfg.transform_enable ? 14'(cfg.pan_y) : 14'sd0);
	end

	// stage 2: clip rectangle and screen bounds
	always_comb begin
		x_w    = 15'(x_s2);
		y_w    = 15'(y_s2);
		clip_l = 15'(cfg.clip_left);
		clip_t = 15'(cfg.clip_top);
		clip_r = clip_l + 15'(cfg.clip_width);
		clip_b = clip_t + 15'(cfg.clip_height);
		in_clip = !cfg.transform_enable
			|| (x_w >= clip_l && x_w < clip_r && y_w >= clip_t && y_w < clip_b);
		on_screen = !x_s2[13] && x_s2 < SCR_W && !y_s2[13] && y_s2 < SCR_H;
	end

	// stage 3: framebuffer address
	always_comb begin
		row_base      = 16'(16'(y_s3) * 16'(SCREEN_W));
		pix.valid     = valid_s3;
		pix.vis       = vis_s3;
		pix.last_scan = last_s3;
		pix.addr      = row_base + 16'(x_s3);
		pix.color     = ink_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1   <= '0;
			valid_s2 <= 1'b0;
			set_s2   <= 1'b0;
			last_s2  <= 1'b0;
			ink_s2   <= '0;
			x_s2     <= '0;
			y_s2     <= '0;
			valid_s3 <= 1'b0;
			vis_s3   <= 1'b0;
			last_s3  <= 1'b0;
			ink_s3   <= '0;
			x_s3     <= '0;
			y_s3     <= '0;
		end else if (en) begin
			tok_s1   <= tok;
			valid_s2 <= tok_s1.valid;
			set_s2   <= bit_set;
			last_s2  <= tok_s1.last_scan;
			ink_s2   <= tok_s1.ink;
			x_s2     <= x_pos;
			y_s2     <= y_pos;
			valid_s3 <= valid_s2;
			vis_s3   <= valid_s2 && set_s2 && in_clip && on_screen;
			last_s3  <= last_s2;
			ink_s3   <= ink_s2;
			x_s3     <= x_s2[XW-1:0];
			y_s3     <= y_s2[YW-1:0];
		end
	end

	a_vis_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && vis_s3 |-> 32'(x_s3) < SCREEN_W && 32'(y_s3) < SCREEN_H)
		else $error("visible pixel outside screen");

endmodule

@@ rtl/fgb_out_stage.sv @@
module fgb_out_stage
	import fgb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pix_t      pix,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_data,
	output logic      en
);

	logic        out_valid_q;
	out_item_t   out_data_q;
	logic        pend_valid_q;
	logic        pend_final_q;
	logic [15:0] pend_addr_q;
	logic [7:0]  pend_color_q;
	logic        emit;
	logic        mark_last;

	assign en = !out_valid_q || out_ready;

	// Hold one visible pixel back until the next visible one or the glyph end shows
	// whether it is the last.
	assign emit = pend_valid_q
		&& (pend_final_q || (pix.valid && (pix.vis || pix.last_scan)));
	assign mark_last = pend_final_q || (pix.valid && pix.last_scan && !pix.vis);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_final_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= emit;
			if (pix.valid && pix.vis) begin
				pend_valid_q <= 1'b1;
				pend_final_q <= pix.last_scan;
			end else if (emit) begin
				pend_valid_q <= 1'b0;
				pend_final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (emit) begin
				out_data_q.pixel_address <= pend_addr_q;
				out_data_q.pixel_color   <= pend_color_q;
				out_data_q.last_pixel    <= mark_last;
			end
			if (pix.valid && pix.vis) begin
				pend_addr_q  <= pix.addr;
				pend_color_q <= pix.color;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_final_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && pend_final_q && en |=> out_valid && out_data.last_pixel)
		else $error("final pixel of glyph not sent as last");

	a_push_on_next: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q && pix.valid && pix.vis && en |=> out_valid)
		else $error("pending pixel lost when next pixel arrived");

	a_result_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pend_valid_q))
		else $error("result sent with no pending pixel");

endmodule

@@ rtl/font_glyph_blitter_core.sv @@
// Character blitter: turns one character request into a stream of framebuffer writes.
// Input channel in_valid/in_ready carries mode, char_code, origin and ink; the output
// channel out_valid/out_ready carries pixel_address, pixel_color and last_pixel, one
// result per visible glyph pixel, the final one of each glyph marked by last_pixel.
// A glyph with no visible pixel produces no result.
// Configuration: cfg_write with cfg_index/cfg_data writes one register in that cycle;
// write only while the block is idle.
// Throughput: the scanner steps one glyph cell per cycle unless the pipe stalls,
// through every cell of the 8x8 or 3x5 glyph, whatever the number of set bits. The next
// request is taken in the cycle the scanner issues the last cell of the current one.
// A cell passes through the font ROM read, transform, clip and address stages to the
// output hold. Each visible pixel waits there until the next visible one or the glyph
// end decides last_pixel. While a result waits with out_ready low the whole pipe holds;
// a request can still be taken while the scanner is idle. Reset clears the config
// registers to zero (transform off) and the scanner, pipeline and output control;
// the request, font ROM row and output data registers are not reset.
module font_glyph_blitter_core
	import fgb_pkg::*;
#(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;

	logic               busy_q;
	logic               mode_q;
	logic [7:0]         code_q;
	logic signed [11:0] ox_q;
	logic signed [11:0] oy_q;
	logic [7:0]         ink_q;
	logic [2:0]         row_q;
	logic [2:0]         col_q;

	logic       en;
	logic       last_col;
	logic       last_row;
	logic       last_pos;
	logic       accept;
	logic [7:0] code_fold;
	scan_t      tok;
	logic [7:0] rom_row;
	pix_t       pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TRANSFORM_ENABLE: cfg_q.transform_enable <= cfg_data[0];
				REG_PAN_X:            cfg_q.pan_x            <= cfg_data;
				REG_PAN_Y:            cfg_q.pan_y            <= cfg_data;
				REG_CLIP_LEFT:        cfg_q.clip_left        <= cfg_data;
				REG_CLIP_TOP:         cfg_q.clip_top         <= cfg_data;
				REG_CLIP_WIDTH:       cfg_q.clip_width       <= cfg_data[10:0];
				REG_CLIP_HEIGHT:      cfg_q.clip_height      <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign last_col = mode_q ? (col_q == SMALL_LAST_COL) : (col_q == BIG_LAST);
	assign last_row = mode_q ? (row_q == SMALL_LAST_ROW) : (row_q == BIG_LAST);
	assign last_pos = last_col && last_row;
	assign in_ready = !busy_q || (en && last_pos);
	assign accept   = in_valid && in_ready;

	assign code_fold = (in_data.char_code >= LOWER_A && in_data.char_code <= LOWER_Z)
		? in_data.char_code - CASE_FOLD : in_data.char_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			row_q  <= '0;
			col_q  <= '0;
		end else if (busy_q && en) begin
			if (last_pos) begin
				busy_q <= 1'b0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_data.mode;
			code_q <= code_fold;
			ox_q   <= in_data.origin_x;
			oy_q   <= in_data.origin_y;
			ink_q  <= in_data.ink;
		end
	end

	always_comb begin
		tok.valid     = busy_q;
		tok.last_scan = last_pos;
		tok.mode      = mode_q;
		tok.char_code = code_q;
		tok.row       = row_q;
		tok.col       = col_q;
		tok.origin_x  = ox_q;
		tok.origin_y  = oy_q;
		tok.ink       = ink_q;
	end

	fgb_font_rom u_rom (
		.clk     (clk),
		.en      (en),
		.tok     (tok),
		.rom_row (rom_row)
	);

	fgb_pixel #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_pixel (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.tok     (tok),
		.rom_row (rom_row),
		.pix     (pix)
	);

	fgb_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.en        (en)
	);

	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !en |=> $stable(row_q) && $stable(col_q) && busy_q)
		else $error("scanner moved while pipe stalled");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && en && last_pos && !in_valid |=> !busy_q)
		else $error("scanner kept running past last cell");

endmodule
